### hdl/lcd_mtc_pkg.sv
// ----------------------------------------------------------------------------
// LCD mode timing controller package
// Shared types and constants for the scan-line mode sequencer.
// ----------------------------------------------------------------------------
package lcd_mtc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OAM_PERIOD       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_PERIOD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HBLANK_PERIOD    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PERIOD      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VBLANK_PERIOD    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BLANK_LINE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_LINE        = 3'd6;

   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   localparam logic [13:0] ACC_MAX = 14'd16383;

   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COINC  = 3;

   typedef enum logic [3:0] {
      ST_HBLANK   = 4'b0001,
      ST_VBLANK   = 4'b0010,
      ST_OAM      = 4'b0100,
      ST_TRANSFER = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [9:0]  oam_period;
      logic [9:0]  transfer_period;
      logic [9:0]  hblank_period;
      logic [9:0]  line_period;
      logic [13:0] vblank_period;
      logic [7:0]  first_blank_line;
      logic [7:0]  last_line;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  line_counter;
      logic [13:0] mode_acc;
      logic [10:0] blank_acc;
      logic        coincidence;
   } state_type;

   typedef struct packed {
      logic [3:0] irq_enables;
      logic [7:0] line_compare;
      logic       lcd_on;
      logic [5:0] cycles;
   } item_type;

   typedef struct packed {
      logic       draw_line;
      logic       stat_irq;
      logic       vblank_irq;
      logic       coincidence;
      logic [7:0] current_line;
      logic [1:0] lcd_mode;
   } result_type;

endpackage

### hdl/lcd_mtc_csr.sv
// ----------------------------------------------------------------------------
// LCD mode timing controller register file
// Holds the period and line registers, written one at a time by index.
// ----------------------------------------------------------------------------
module lcd_mtc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [lcd_mtc_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [lcd_mtc_pkg::CSR_DATA_W-1:0]  wr_data,
   output lcd_mtc_pkg::cfg_type                cfg
);
   import lcd_mtc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_OAM_PERIOD:       cfg_in.oam_period       = wr_data[9:0];
            CSR_TRANSFER_PERIOD:  cfg_in.transfer_period  = wr_data[9:0];
            CSR_HBLANK_PERIOD:    cfg_in.hblank_period    = wr_data[9:0];
            CSR_LINE_PERIOD:      cfg_in.line_period      = wr_data[9:0];
            CSR_VBLANK_PERIOD:    cfg_in.vblank_period    = wr_data[13:0];
            CSR_FIRST_BLANK_LINE: cfg_in.first_blank_line = wr_data[7:0];
            CSR_LAST_LINE:        cfg_in.last_line        = wr_data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oam_period       <= 10'd80;
         cfg_ff.transfer_period  <= 10'd172;
         cfg_ff.hblank_period    <= 10'd204;
         cfg_ff.line_period      <= 10'd456;
         cfg_ff.vblank_period    <= 14'd4560;
         cfg_ff.first_blank_line <= 8'd144;
         cfg_ff.last_line        <= 8'd153;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/lcd_mtc_step.sv
// ----------------------------------------------------------------------------
// LCD mode timing controller step logic
// Computes the next sequencer state and the result of one tick.
// ----------------------------------------------------------------------------
module lcd_mtc_step (
   input  lcd_mtc_pkg::cfg_type    cfg,
   input  lcd_mtc_pkg::state_type  cur,
   input  lcd_mtc_pkg::item_type   item,
   output lcd_mtc_pkg::state_type  nxt,
   output lcd_mtc_pkg::result_type res
);
   import lcd_mtc_pkg::*;

   logic [14:0] acc_sum;
   logic [13:0] acc;
   logic [10:0] blank_sum;
   logic [7:0]  line_inc;
   logic [7:0]  line_step;
   logic        vbl;
   logic        stat;
   logic        draw;

   always_comb begin
      acc_sum   = {1'b0, cur.mode_acc} + {9'd0, item.cycles};
      acc       = acc_sum[14] ? ACC_MAX : acc_sum[13:0];
      blank_sum = cur.blank_acc + {5'd0, item.cycles};
      line_inc  = cur.line_counter + 8'd1;
      line_step = cur.line_counter;
      nxt       = cur;
      vbl       = 1'b0;
      stat      = 1'b0;
      draw      = 1'b0;

      if (!item.lcd_on) begin
         nxt.mode         = ST_HBLANK;
         nxt.line_counter = 8'd0;
         nxt.mode_acc     = 14'd0;
         nxt.blank_acc    = 11'd0;
      end else begin
         nxt.mode_acc = acc;
         case (cur.mode)
            ST_HBLANK: begin
               if (acc >= {4'd0, cfg.hblank_period}) begin
                  nxt.mode_acc     = acc - {4'd0, cfg.hblank_period};
                  nxt.line_counter = line_inc;
                  nxt.coincidence  = (item.line_compare == line_inc);
                  stat = nxt.coincidence & item.irq_enables[IRQ_EN_COINC];
                  if (line_inc == cfg.first_blank_line) begin
                     nxt.mode = ST_VBLANK;
                     vbl      = 1'b1;
                     stat     = stat | item.irq_enables[IRQ_EN_VBLANK];
                  end else begin
                     nxt.mode = ST_OAM;
                     stat     = stat | item.irq_enables[IRQ_EN_OAM];
                  end
               end
            end
            ST_VBLANK: begin
               nxt.blank_acc = blank_sum;
               if (blank_sum >= {1'b0, cfg.line_period}) begin
                  nxt.blank_acc = 11'd0;
                  if (cur.line_counter < cfg.last_line) begin
                     line_step = line_inc;
                  end
                  nxt.line_counter = line_step;
                  nxt.coincidence  = (item.line_compare == line_step);
                  stat = nxt.coincidence & item.irq_enables[IRQ_EN_COINC];
               end
               if (acc >= cfg.vblank_period) begin
                  nxt.blank_acc    = 11'd0;
                  nxt.mode_acc     = 14'd0;
                  nxt.line_counter = 8'd0;
                  nxt.coincidence  = (item.line_compare == 8'd0);
                  nxt.mode         = ST_OAM;
                  stat = stat | (nxt.coincidence & item.irq_enables[IRQ_EN_COINC])
                         | item.irq_enables[IRQ_EN_OAM];
               end
            end
            ST_OAM: begin
               if (acc >= {4'd0, cfg.oam_period}) begin
                  nxt.mode_acc = acc - {4'd0, cfg.oam_period};
                  nxt.mode     = ST_TRANSFER;
               end
            end
            ST_TRANSFER: begin
               if (acc >= {4'd0, cfg.transfer_period}) begin
                  nxt.mode_acc = acc - {4'd0, cfg.transfer_period};
                  nxt.mode     = ST_HBLANK;
                  draw         = 1'b1;
                  stat         = item.irq_enables[IRQ_EN_HBLANK];
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end

      case (nxt.mode)
         ST_HBLANK:   res.lcd_mode = MODE_HBLANK;
         ST_VBLANK:   res.lcd_mode = MODE_VBLANK;
         ST_OAM:      res.lcd_mode = MODE_OAM;
         ST_TRANSFER: res.lcd_mode = MODE_TRANSFER;
         default:     res.lcd_mode = MODE_HBLANK;
      endcase
      res.current_line = nxt.line_counter;
      res.coincidence  = nxt.coincidence;
      res.vblank_irq   = vbl;
      res.stat_irq     = stat;
      res.draw_line    = draw;
   end

endmodule

### hdl/lcd_mode_timing_controller.sv
// ----------------------------------------------------------------------------
// LCD mode timing controller
// Steps the scan-line mode, line counter and coincidence flag once per tick.
// ----------------------------------------------------------------------------
// A request is registered in in_item_ff, its result in out_ff for rsp_tdata.
// Throughput: one tick per cycle unless rsp_tready stalls the response.
// Reset clears the pipeline valid flags, returns the sequencer to OAM search
// at line zero with empty accumulators, and loads the default periods.
// The register port is always ready.
module lcd_mode_timing_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cycles[5:0], lcd_on[6], line_compare[14:7], irq_enables[18:15], zero pad
   input  logic [lcd_mtc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // lcd_mode[1:0], current_line[9:2], coincidence[10], vblank_irq[11],
   // stat_irq[12], draw_line[13], zero pad
   output logic [lcd_mtc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcd_mtc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcd_mtc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lcd_mtc_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   logic       out_load;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;

   lcd_mtc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   lcd_mtc_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .res  (step_res)
   );

   assign out_load     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_load;
   assign req_tready   = !in_valid_ff || advance;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.mode         <= ST_OAM;
         state_ff.line_counter <= 8'd0;
         state_ff.mode_acc     <= 14'd0;
         state_ff.blank_acc    <= 11'd0;
         state_ff.coincidence  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= item_type'(req_tdata[18:0]);
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   a_vblank_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.vblank_irq) |-> (out_ff.lcd_mode == MODE_VBLANK))
      else $error("vblank interrupt without vblank mode");

   a_draw_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.draw_line) |-> (out_ff.lcd_mode == MODE_HBLANK))
      else $error("draw pulse outside hblank entry");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("sequencer state changed without a tick");

   a_reset_empty : assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_tvalid && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
